[src/vsc_pkg.sv]
`default_nettype none

package vsc_pkg;

  // Volume geometry and storage word
  localparam int MAX_DIM    = 32;
  localparam int VALUE_BITS = 24;

  localparam int DIM_BITS  = $clog2(MAX_DIM);
  localparam int ADDR_BITS = 3 * DIM_BITS;

  // Fixed field widths
  localparam int COORD_BITS = 6;
  localparam int SIZE_BITS  = 6;
  localparam int DIN_BITS   = 24;
  localparam int THR_BITS   = 23;
  localparam int NB_BITS    = COORD_BITS + 1;
  localparam int CFG_IDX_BITS  = 8;
  localparam int CFG_DATA_BITS = 23;

  localparam int S_TDATA_BITS = 48;
  localparam int M_TDATA_BITS = 32;

  // Signed compare width: holds any stored value and the unsigned threshold
  localparam int CMP_BITS = ((VALUE_BITS > DIN_BITS) ? VALUE_BITS : DIN_BITS) + 1;

  localparam logic signed [CMP_BITS-1:0] VAL_MAX =
    CMP_BITS'((64'sd1 <<< (VALUE_BITS - 1)) - 64'sd1);
  localparam logic signed [CMP_BITS-1:0] VAL_MIN = -VAL_MAX - CMP_BITS'(1);

  localparam logic [SIZE_BITS-1:0] SIZE_RESET = SIZE_BITS'(32);
  localparam logic [THR_BITS-1:0]  THR_RESET  = THR_BITS'(7);
  localparam logic [NB_BITS-1:0]   DIM_LIMIT  = NB_BITS'(MAX_DIM);

  typedef logic [VALUE_BITS-1:0] val_t;
  typedef logic [ADDR_BITS-1:0]  addr_t;

  typedef enum logic {
    CMD_WRITE = 1'b0,
    CMD_QUERY = 1'b1
  } cmd_t;

  localparam logic [CFG_IDX_BITS-1:0] REG_SIZE_X    = CFG_IDX_BITS'(0);
  localparam logic [CFG_IDX_BITS-1:0] REG_SIZE_Y    = CFG_IDX_BITS'(1);
  localparam logic [CFG_IDX_BITS-1:0] REG_SIZE_Z    = CFG_IDX_BITS'(2);
  localparam logic [CFG_IDX_BITS-1:0] REG_THRESHOLD = CFG_IDX_BITS'(3);

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_READ,
    ST_DRAIN,
    ST_DONE
  } state_t;

  // Probe order over the six faces after the centre
  localparam logic [2:0] PRB_CENTRE = 3'd0;
  localparam logic [2:0] PRB_YP     = 3'd1;
  localparam logic [2:0] PRB_YM     = 3'd2;
  localparam logic [2:0] PRB_XP     = 3'd3;
  localparam logic [2:0] PRB_XM     = 3'd4;
  localparam logic [2:0] PRB_ZP     = 3'd5;
  localparam logic [2:0] PRB_ZM     = 3'd6;

  function automatic logic signed [CMP_BITS-1:0] widen(input val_t v);
    widen = {{(CMP_BITS - VALUE_BITS){v[VALUE_BITS-1]}}, v};
  endfunction

  // Saturate a written density to the storage word
  function automatic val_t limit_value(input logic [DIN_BITS-1:0] d);
    logic signed [CMP_BITS-1:0] ext;
    ext = {{(CMP_BITS - DIN_BITS){d[DIN_BITS-1]}}, d};
    if (ext > VAL_MAX) begin
      limit_value = VALUE_BITS'(VAL_MAX);
    end else if (ext < VAL_MIN) begin
      limit_value = VALUE_BITS'(VAL_MIN);
    end else begin
      limit_value = VALUE_BITS'(ext);
    end
  endfunction

  function automatic logic [NB_BITS-1:0] eff_size(input logic [SIZE_BITS-1:0] s);
    logic [NB_BITS-1:0] w;
    w = {1'b0, s};
    eff_size = (w > DIM_LIMIT) ? DIM_LIMIT : w;
  endfunction

endpackage

`default_nettype wire

[src/vsc_voxel_ram.sv]
`default_nettype none

module vsc_voxel_ram #(
  parameter int ADDR_W = 15,
  parameter int DATA_W = 24
) (
  input  wire logic              clk,
  input  wire logic              we,
  input  wire logic [ADDR_W-1:0] addr,
  input  wire logic [DATA_W-1:0] wdata,
  output logic      [DATA_W-1:0] rdata
);

  logic [DATA_W-1:0] mem [(1 << ADDR_W)];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

`default_nettype wire

[src/voxel_surface_classifier_top.sv]
// Voxel surface classifier.
// Input stream (s_*): one beat is a command. s_tuser carries the command
// (write or query), s_tdata the coordinates and the density to store.
// Output stream (m_*): exactly one result beat per input beat, in order.
// Configuration channel (cfg_*): always ready; writes the volume size along
// each axis and the occupancy threshold. The user must write only while no
// item is in flight; the block itself does not enforce this. All voxels sit
// in one single-port synchronous RAM of 2^(3*DIM_BITS) words. A query reads
// the centre and its six face neighbours through that one port, one read
// per cycle, in ST_READ, then passes ST_DRAIN to ST_DONE, where the result
// is loaded into the output register and m_tvalid rises; a write or an
// outside query goes from ST_IDLE straight to ST_DONE. One item is worked
// on at a time; the next beat is taken the cycle after the result has moved
// into the output register. After reset the RAM is swept to zero, one word
// per cycle; s_tready stays low during the sweep. If the receiver stalls,
// the result holds in the output register, one further item may be accepted
// and worked on, and it then waits until the register is free.
`default_nettype none

module voxel_surface_classifier_top (
  input  wire logic                                 clk,
  input  wire logic                                 rst,
  input  wire logic                                 s_tvalid,
  output logic                                      s_tready,
  // [5:0] coord_x, [11:6] coord_y, [17:12] coord_z, [41:18] density_in
  input  wire logic [vsc_pkg::S_TDATA_BITS-1:0]     s_tdata,
  // [0] command
  input  wire logic                                 s_tuser,
  output logic                                      m_tvalid,
  input  wire logic                                 m_tready,
  // [23:0] density_out, [24] inside_res, [25] occupied, [26] on_surface
  output logic [vsc_pkg::M_TDATA_BITS-1:0]          m_tdata,
  input  wire logic                                 cfg_valid,
  output logic                                      cfg_ready,
  input  wire logic [vsc_pkg::CFG_IDX_BITS-1:0]     cfg_index,
  input  wire logic [vsc_pkg::CFG_DATA_BITS-1:0]    cfg_data
);

  import vsc_pkg::*;

  // Configuration registers
  logic [SIZE_BITS-1:0] size_x, size_y, size_z;
  logic [THR_BITS-1:0]  threshold;

  state_t state, state_next;

  // Item held for the duration of its work
  cmd_t                  cmd;
  logic [COORD_BITS-1:0] cx, cy, cz;
  logic [DIN_BITS-1:0]   din;
  logic                  item_in_vol;

  logic [2:0]     prb_idx;
  logic           rd_pend;
  logic [2:0]     rd_idx;
  logic           rd_ok;
  val_t           centre;
  logic           hit;
  addr_t          clr_addr;

  logic           mem_we;
  addr_t          mem_addr;
  val_t           mem_wdata;
  val_t           mem_rdata;

  logic           accept;
  logic           out_free;
  logic           load_out;
  logic           in_inside;
  logic [NB_BITS-1:0] effx, effy, effz;
  logic [NB_BITS-1:0] nx, ny, nz;
  logic           nb_ok;
  addr_t          nb_addr;
  addr_t          item_addr;
  logic signed [CMP_BITS-1:0] thr_w;
  logic signed [CMP_BITS-1:0] centre_w;
  logic [M_TDATA_BITS-1:0] result;

  assign cfg_ready = 1'b1;
  assign s_tready  = (state == ST_IDLE);
  assign accept    = s_tvalid && s_tready;
  assign out_free  = !m_tvalid || m_tready;
  assign load_out  = (state == ST_DONE) && out_free;

  assign effx  = eff_size(size_x);
  assign effy  = eff_size(size_y);
  assign effz  = eff_size(size_z);
  assign thr_w = {{(CMP_BITS - THR_BITS){1'b0}}, threshold};

  assign in_inside = ({1'b0, s_tdata[5:0]}   < effx) &&
                     ({1'b0, s_tdata[11:6]}  < effy) &&
                     ({1'b0, s_tdata[17:12]} < effz);

  always_ff @(posedge clk) begin
    if (rst) begin
      size_x    <= SIZE_RESET;
      size_y    <= SIZE_RESET;
      size_z    <= SIZE_RESET;
      threshold <= THR_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_SIZE_X:    size_x    <= cfg_data[SIZE_BITS-1:0];
        REG_SIZE_Y:    size_y    <= cfg_data[SIZE_BITS-1:0];
        REG_SIZE_Z:    size_z    <= cfg_data[SIZE_BITS-1:0];
        REG_THRESHOLD: threshold <= cfg_data[THR_BITS-1:0];
        default: ;
      endcase
    end
  end

  // Neighbour coordinate for the current probe; a step below zero wraps to
  // a large value and so falls outside on its own
  always_comb begin
    nx = {1'b0, cx};
    ny = {1'b0, cy};
    nz = {1'b0, cz};
    case (prb_idx)
      PRB_YP: ny = {1'b0, cy} + NB_BITS'(1);
      PRB_YM: ny = {1'b0, cy} - NB_BITS'(1);
      PRB_XP: nx = {1'b0, cx} + NB_BITS'(1);
      PRB_XM: nx = {1'b0, cx} - NB_BITS'(1);
      PRB_ZP: nz = {1'b0, cz} + NB_BITS'(1);
      PRB_ZM: nz = {1'b0, cz} - NB_BITS'(1);
      default: ;
    endcase
  end

  assign nb_ok     = (nx < effx) && (ny < effy) && (nz < effz);
  assign nb_addr   = {nz[DIM_BITS-1:0], ny[DIM_BITS-1:0], nx[DIM_BITS-1:0]};
  assign item_addr = {cz[DIM_BITS-1:0], cy[DIM_BITS-1:0], cx[DIM_BITS-1:0]};

  // Single RAM port: sweep, write-back or probe
  always_comb begin
    mem_we    = 1'b0;
    mem_addr  = nb_addr;
    mem_wdata = limit_value(din);
    case (state)
      ST_CLEAR: begin
        mem_we    = 1'b1;
        mem_addr  = clr_addr;
        mem_wdata = '0;
      end
      ST_DONE: begin
        mem_addr = item_addr;
        mem_we   = load_out && (cmd == CMD_WRITE) && item_in_vol;
      end
      default: ;
    endcase
  end

  vsc_voxel_ram #(
    .ADDR_W (ADDR_BITS),
    .DATA_W (VALUE_BITS)
  ) u_ram (
    .clk   (clk),
    .we    (mem_we),
    .addr  (mem_addr),
    .wdata (mem_wdata),
    .rdata (mem_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_CLEAR: begin
        if (clr_addr == '1) state_next = ST_IDLE;
      end
      ST_IDLE: begin
        if (accept) begin
          if ((cmd_t'(s_tuser) == CMD_QUERY) && in_inside) state_next = ST_READ;
          else                                              state_next = ST_DONE;
        end
      end
      ST_READ: begin
        if (prb_idx == PRB_ZM) state_next = ST_DRAIN;
      end
      ST_DRAIN: state_next = ST_DONE;
      ST_DONE: begin
        if (out_free) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      clr_addr <= '0;
      rd_pend  <= 1'b0;
      prb_idx  <= PRB_CENTRE;
    end else begin
      if (state == ST_CLEAR) clr_addr <= clr_addr + ADDR_BITS'(1);
      rd_pend <= (state == ST_READ);
      if (state == ST_READ) prb_idx <= prb_idx + 3'd1;
      else                  prb_idx <= PRB_CENTRE;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      cmd         <= cmd_t'(s_tuser);
      cx          <= s_tdata[5:0];
      cy          <= s_tdata[11:6];
      cz          <= s_tdata[17:12];
      din         <= s_tdata[41:18];
      item_in_vol <= in_inside;
    end
    if (state == ST_READ) begin
      rd_idx <= prb_idx;
      rd_ok  <= nb_ok;
    end
    // Fold each read beat: centre value first, then any face above threshold
    if (accept) begin
      hit <= 1'b0;
    end else if (rd_pend) begin
      if (rd_idx == PRB_CENTRE) centre <= mem_rdata;
      else if (rd_ok && (widen(mem_rdata) > thr_w)) hit <= 1'b1;
    end
  end

  assign centre_w = widen(centre);

  always_comb begin
    result = '0;
    if (cmd == CMD_QUERY) begin
      if (item_in_vol) begin
        result[23:0] = centre_w[23:0];
        result[24]   = 1'b1;
        result[25]   = centre_w > thr_w;
        result[26]   = (centre_w < thr_w) && hit;
      end
    end else begin
      result[24] = item_in_vol;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (load_out) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) m_tdata <= result;
  end

  // Only one item in flight: no second beat right after an accept
  a_single_item: assert property (@(posedge clk) disable iff (rst)
    accept |=> !s_tready)
    else $error("input beat accepted while an item is in flight");

  // Probing must never be disturbed by a RAM write
  a_no_write_in_probe: assert property (@(posedge clk) disable iff (rst)
    (state == ST_READ || state == ST_DRAIN) |-> !mem_we)
    else $error("RAM write during neighbour probe");

  // Read data is only folded in the cycle after a probe issue
  a_read_follows_probe: assert property (@(posedge clk) disable iff (rst)
    rd_pend |-> $past(state) == ST_READ)
    else $error("read beat without a probe");

  // A result is only loaded once the previous one has left
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tready) |-> !load_out)
    else $error("result register overwritten while stalled");

endmodule

`default_nettype wire
